[sv/combined_lcg_shuffle_rng_defines.svh]
// Assertion macros used by the controller of the shuffled generator.
`ifndef COMBINED_LCG_SHUFFLE_RNG_DEFINES_SVH
`define COMBINED_LCG_SHUFFLE_RNG_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLSR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("clsr assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CLSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clsr assertion failed");

`endif

[sv/clsr_pkg.sv]
`default_nettype none

package clsr_pkg;

    localparam int TABLE_DEPTH_DEF = 32;

    // Moduli, multipliers and the folding constants 2^31 - modulus.
    localparam logic [31:0] MOD_A  = 32'd2147483563;
    localparam logic [31:0] MOD_B  = 32'd2147483399;
    localparam logic [15:0] MUL_A  = 16'd40014;
    localparam logic [15:0] MUL_B  = 16'd40692;
    localparam logic [7:0]  FOLD_A = 8'd85;
    localparam logic [7:0]  FOLD_B = 8'd249;

    localparam logic [31:0] RANGE_TOP    = 32'd2147483562;
    localparam logic [30:0] RESET_FIRST  = 31'd1;
    localparam logic [30:0] RESET_SECOND = 31'd123456789;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SMUL,
        ST_SFOLD,
        ST_SRED,
        ST_DMUL,
        ST_DFOLD,
        ST_DRED,
        ST_DOUT
    } t_state;

    typedef struct packed {
        logic load_seed;
        logic mul;
        logic fold;
        logic upd_a;
        logic upd_b;
        logic fill_wr;
        logic set_sout;
        logic rd;
        logic fin;
    } t_dp_cmd;

    typedef struct packed {
        logic out_full;
    } t_dp_sts;

endpackage

`default_nettype wire

[sv/clsr_dp.sv]
`default_nettype none

module clsr_dp #(
    parameter int TABLE_DEPTH = clsr_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire clsr_pkg::t_dp_cmd              i_cmd,
    input  wire logic [$clog2(TABLE_DEPTH)-1:0] i_fill_idx,
    input  wire logic [30:0]                    i_seed,
    input  wire logic                           i_out_ready,
    output clsr_pkg::t_dp_sts                   o_sts,
    output logic [30:0]                         o_deviate,
    output logic                                o_out_valid
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int RW = $clog2(TABLE_DEPTH) + 2;
    localparam logic [31:0] SLOT_DIV = 32'd1 + clsr_pkg::RANGE_TOP / TABLE_DEPTH;
    localparam logic [32:0] SLOT_RCP = (33'd1 << 31) / {1'b0, SLOT_DIV};

    // Generator state and the shuffle output.
    logic [30:0] r_first;
    logic [30:0] r_second;
    logic [30:0] r_shuffle_out;

    // Pipeline registers of the modular step and of the slot division.
    logic [46:0]   r_prod_a;
    logic [46:0]   r_prod_b;
    logic [31:0]   r_fold_a;
    logic [31:0]   r_fold_b;
    logic [RW-1:0] r_q0;
    logic [AW-1:0] r_slot;

    // Shuffle table with valid bits that stand for the cleared reset contents.
    logic [30:0]            r_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_vld;
    logic [30:0]            r_rd;
    logic                   r_rd_vld;

    logic [30:0] r_deviate;
    logic        r_out_valid;

    logic [30:0]      w_seed;
    logic [23:0]      w_hi_a;
    logic [23:0]      w_hi_b;
    logic [30:0]      n_first;
    logic [30:0]      n_second;
    logic [RW+30:0]   w_q_prod;
    logic [RW-1:0]    w_q1;
    logic [RW+31:0]   w_thr;
    logic [RW-1:0]    w_qc;
    logic [AW-1:0]    n_slot;
    logic [30:0]      w_rd;
    logic [31:0]      w_diff;
    logic [31:0]      w_wrap;
    logic [30:0]      n_deviate;

    assign w_seed = (i_seed == '0) ? 31'd1 : i_seed;

    // The high part of the product is folded back with 2^31 = c (mod m).
    assign w_hi_a = {8'b0, r_prod_a[46:31]} * {16'b0, clsr_pkg::FOLD_A};
    assign w_hi_b = {8'b0, r_prod_b[46:31]} * {16'b0, clsr_pkg::FOLD_B};

    // The folded sum is below twice the modulus, so one subtraction finishes it.
    assign n_first  = (r_fold_a >= clsr_pkg::MOD_A) ?
                      31'(r_fold_a - clsr_pkg::MOD_A) : r_fold_a[30:0];
    assign n_second = (r_fold_b >= clsr_pkg::MOD_B) ?
                      31'(r_fold_b - clsr_pkg::MOD_B) : r_fold_b[30:0];

    // Slot estimate by reciprocal, at most one below the true quotient.
    assign w_q_prod = {{RW{1'b0}}, r_shuffle_out} * {31'b0, SLOT_RCP[RW-1:0]};
    assign w_q1     = r_q0 + RW'(1);
    assign w_thr    = {32'b0, w_q1} * {{RW{1'b0}}, SLOT_DIV};
    assign w_qc     = ({{(RW+1){1'b0}}, r_shuffle_out} >= w_thr) ? w_q1 : r_q0;
    assign n_slot   = (w_qc >= RW'(TABLE_DEPTH)) ? AW'(TABLE_DEPTH - 1) : w_qc[AW-1:0];

    assign w_rd      = r_rd_vld ? r_rd : '0;
    assign w_diff    = {1'b0, w_rd} - {1'b0, r_second};
    assign w_wrap    = w_diff + clsr_pkg::RANGE_TOP;
    assign n_deviate = (w_rd > r_second) ? w_diff[30:0] : w_wrap[30:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first       <= clsr_pkg::RESET_FIRST;
            r_second      <= clsr_pkg::RESET_SECOND;
            r_shuffle_out <= '0;
            r_vld         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.load_seed) begin
                r_first  <= w_seed;
                r_second <= w_seed;
            end else begin
                if (i_cmd.upd_a) begin
                    r_first <= n_first;
                end
                if (i_cmd.upd_b) begin
                    r_second <= n_second;
                end
            end
            if (i_cmd.set_sout) begin
                r_shuffle_out <= n_first;
            end else if (i_cmd.fin) begin
                r_shuffle_out <= n_deviate;
            end
            if (i_cmd.fill_wr) begin
                r_vld[i_fill_idx] <= 1'b1;
            end else if (i_cmd.fin) begin
                r_vld[r_slot] <= 1'b1;
            end
            if (i_cmd.fin) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod_a <= {16'b0, r_first} * {31'b0, clsr_pkg::MUL_A};
            r_prod_b <= {16'b0, r_second} * {31'b0, clsr_pkg::MUL_B};
            r_q0     <= w_q_prod[RW+30:31];
        end
        if (i_cmd.fold) begin
            r_fold_a <= {8'b0, w_hi_a} + {1'b0, r_prod_a[30:0]};
            r_fold_b <= {8'b0, w_hi_b} + {1'b0, r_prod_b[30:0]};
            r_slot   <= n_slot;
        end
        if (i_cmd.fin) begin
            r_deviate <= n_deviate;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fill_wr) begin
            r_mem[i_fill_idx] <= n_first;
        end else if (i_cmd.fin) begin
            r_mem[r_slot] <= r_first;
        end
        if (i_cmd.rd) begin
            r_rd     <= r_mem[r_slot];
            r_rd_vld <= r_vld[r_slot];
        end
    end

    assign o_sts.out_full = r_out_valid & ~i_out_ready;
    assign o_deviate      = r_deviate;
    assign o_out_valid    = r_out_valid;

endmodule

`default_nettype wire

[sv/clsr_ctrl.sv]
`default_nettype none

`include "combined_lcg_shuffle_rng_defines.svh"

module clsr_ctrl #(
    parameter int TABLE_DEPTH = clsr_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    input  wire logic                           i_mode,
    input  wire clsr_pkg::t_dp_sts              i_sts,
    output logic                                o_in_ready,
    output clsr_pkg::t_dp_cmd                   o_cmd,
    output logic [$clog2(TABLE_DEPTH)-1:0]      o_fill_idx
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 8);
    localparam logic [CW-1:0] CNT_TOP = CW'(TABLE_DEPTH + 7);

    clsr_pkg::t_state r_state;
    clsr_pkg::t_state n_state;
    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    n_cnt;
    logic             w_take;

    assign w_take = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= clsr_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            clsr_pkg::ST_IDLE, clsr_pkg::ST_DOUT: begin
                if (w_take) begin
                    if (i_mode) begin
                        n_state = clsr_pkg::ST_SMUL;
                        n_cnt   = CNT_TOP;
                    end else begin
                        n_state = clsr_pkg::ST_DMUL;
                    end
                end else if (r_state == clsr_pkg::ST_DOUT && !i_sts.out_full) begin
                    n_state = clsr_pkg::ST_IDLE;
                end
            end
            clsr_pkg::ST_SMUL:  n_state = clsr_pkg::ST_SFOLD;
            clsr_pkg::ST_SFOLD: n_state = clsr_pkg::ST_SRED;
            clsr_pkg::ST_SRED: begin
                if (r_cnt == '0) begin
                    n_state = clsr_pkg::ST_DMUL;
                end else begin
                    n_state = clsr_pkg::ST_SMUL;
                    n_cnt   = r_cnt - CW'(1);
                end
            end
            clsr_pkg::ST_DMUL:  n_state = clsr_pkg::ST_DFOLD;
            clsr_pkg::ST_DFOLD: n_state = clsr_pkg::ST_DRED;
            clsr_pkg::ST_DRED:  n_state = clsr_pkg::ST_DOUT;
            default:            n_state = clsr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == clsr_pkg::ST_IDLE) ||
                     (r_state == clsr_pkg::ST_DOUT && !i_sts.out_full);
        o_cmd.load_seed = w_take && i_mode;
        o_cmd.mul       = r_state inside {clsr_pkg::ST_SMUL, clsr_pkg::ST_DMUL};
        o_cmd.fold      = r_state inside {clsr_pkg::ST_SFOLD, clsr_pkg::ST_DFOLD};
        o_cmd.upd_a     = r_state inside {clsr_pkg::ST_SRED, clsr_pkg::ST_DRED};
        o_cmd.upd_b     = (r_state == clsr_pkg::ST_DRED);
        o_cmd.fill_wr   = (r_state == clsr_pkg::ST_SRED) && (r_cnt < CW'(TABLE_DEPTH));
        o_cmd.set_sout  = (r_state == clsr_pkg::ST_SRED) && (r_cnt == '0);
        o_cmd.rd        = (r_state == clsr_pkg::ST_DRED);
        o_cmd.fin       = (r_state == clsr_pkg::ST_DOUT) && !i_sts.out_full;
        o_fill_idx      = r_cnt[AW-1:0];
    end

    // A plain draw request goes straight to the multiply step.
    `CLSR_ASSERT_NEXT(a_draw_start, i_clk, i_rst_n, w_take && !i_mode,
        r_state == clsr_pkg::ST_DMUL)
    // A reseed request starts the warm-up with the full step count.
    `CLSR_ASSERT_NEXT(a_seed_start, i_clk, i_rst_n, w_take && i_mode,
        r_state == clsr_pkg::ST_SMUL && r_cnt == CNT_TOP)
    // The last warm-up step hands over to the draw.
    `CLSR_ASSERT_NEXT(a_seed_end, i_clk, i_rst_n,
        r_state == clsr_pkg::ST_SRED && r_cnt == '0, r_state == clsr_pkg::ST_DMUL)
    // A finished draw waits while the output register is still occupied.
    `CLSR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        r_state == clsr_pkg::ST_DOUT && i_sts.out_full, r_state == clsr_pkg::ST_DOUT)

endmodule

`default_nettype wire

[sv/combined_lcg_shuffle_rng.sv]
// A draw request steps through the multiply, fold, reduce and output states;
// in the output state the deviate is loaded into the output register once that
// register is free. A new request is taken only in the idle or output state.
// A reseed adds a warm-up of TABLE_DEPTH + 8 steps of the first generator.
// Reset (synchronous, active low) sets the generators to 1 and 123456789 and
// the shuffle output to zero; the table reads as zero until written.
`default_nettype none

module combined_lcg_shuffle_rng #(
    parameter int TABLE_DEPTH = clsr_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_mode,
    input  wire logic [30:0] i_seed,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [30:0]      o_deviate
);

    // The controller sequences each request: a reseed runs the first
    // generator through TABLE_DEPTH + 8 steps, writing the last TABLE_DEPTH
    // values into the shuffle table from the top entry down, and then falls
    // into an ordinary draw.
    //
    // A draw steps both generators in parallel through three modular stages
    // (multiply, fold of the high part, final subtraction) while the slot is
    // worked out from the previous shuffle output by a reciprocal multiply
    // with one correction. The table entry is read in the reduce state and
    // replaced by the new first generator value in the output state, when
    // the deviate is loaded into the output register.
    //
    // The output register lets a new request be taken in the cycle in which
    // a result is delivered, so draws follow one another without a gap.

    clsr_pkg::t_dp_cmd              w_cmd;
    clsr_pkg::t_dp_sts              w_sts;
    logic [$clog2(TABLE_DEPTH)-1:0] w_fill_idx;

    clsr_ctrl #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_sts      (w_sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd),
        .o_fill_idx (w_fill_idx)
    );

    clsr_dp #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_fill_idx  (w_fill_idx),
        .i_seed      (i_seed),
        .i_out_ready (i_out_ready),
        .o_sts       (w_sts),
        .o_deviate   (o_deviate),
        .o_out_valid (o_out_valid)
    );

endmodule

`default_nettype wire

[tb/combined_lcg_shuffle_rng_tb.sv]
`timescale 1ns / 100ps

// Scoreboard for the shuffled combined generator. It keeps its own copy of
// both generator states, the shuffle output and the shuffle table, works out
// the deviate of each accepted request and checks the deviates that come back
// in order.
class deviate_scoreboard;

    localparam int DEPTH = clsr_pkg::TABLE_DEPTH_DEF;

    bit [30:0] gen_a;
    bit [30:0] gen_b;
    bit [30:0] last_out;
    bit [30:0] slots [DEPTH];
    bit [30:0] expected_deviates [$];
    int        n_errors;

    function new();
        gen_a    = clsr_pkg::RESET_FIRST;
        gen_b    = clsr_pkg::RESET_SECOND;
        last_out = '0;
        foreach (slots[i]) slots[i] = '0;
        n_errors = 0;
    endfunction

    // One exact multiplicative congruential step, (mul * x) mod modulus.
    function bit [30:0] lcg_step(bit [30:0] x, bit [31:0] mul, bit [31:0] modulus);
        longint unsigned prod;
        prod = 64'(x);
        prod = (prod * 64'(mul)) % 64'(modulus);
        return prod[30:0];
    endfunction

    function void note_request(bit mode, bit [30:0] seed);
        bit [30:0]   start;
        int          n;
        int unsigned slot;
        longint      diff;
        longint      entry;
        longint      sub;
        if (mode == 1'b1) begin
            start = (seed == '0) ? 31'd1 : seed;
            gen_a = start;
            gen_b = start;
            // Warm-up: eight discarded steps, then the table fills from the top down.
            for (n = DEPTH + 7; n >= 0; n--) begin
                gen_a = lcg_step(gen_a, 32'(clsr_pkg::MUL_A), clsr_pkg::MOD_A);
                if (n < DEPTH)
                    slots[n] = gen_a;
            end
            last_out = slots[0];
        end
        gen_a = lcg_step(gen_a, 32'(clsr_pkg::MUL_A), clsr_pkg::MOD_A);
        gen_b = lcg_step(gen_b, 32'(clsr_pkg::MUL_B), clsr_pkg::MOD_B);
        slot = 32'(last_out) / (32'd1 + clsr_pkg::RANGE_TOP / DEPTH);
        if (slot >= DEPTH)
            slot = DEPTH - 1;
        entry = longint'(slots[slot]);
        sub   = longint'(gen_b);
        diff  = entry - sub;
        slots[slot] = gen_a;
        if (diff < 1)
            diff = diff + longint'(clsr_pkg::RANGE_TOP);
        last_out = diff[30:0];
        expected_deviates.push_back(last_out);
    endfunction

    function void check_deviate(bit [30:0] got);
        bit [30:0] want;
        if (expected_deviates.size() == 0) begin
            $error("deviate arrived with no request outstanding: actual %0d", got);
            n_errors++;
        end else begin
            want = expected_deviates.pop_front();
            if (got !== want) begin
                $error("deviate mismatch: expected %0d, actual %0d", want, got);
                n_errors++;
            end
        end
    endfunction

endclass

module combined_lcg_shuffle_rng_tb;

    // Request modes of the generator.
    localparam bit MODE_DRAW   = 1'b0;
    localparam bit MODE_RESEED = 1'b1;

    // Seeds of interest: the largest in range, both moduli (each leaves one
    // generator stuck at zero) and the all-ones pattern.
    localparam bit [30:0] SEED_TOP    = 31'd2147483562;
    localparam bit [30:0] SEED_MOD_A  = 31'd2147483563;
    localparam bit [30:0] SEED_MOD_B  = 31'd2147483399;
    localparam bit [30:0] SEED_ONES   = 31'h7FFF_FFFF;

    localparam int RANDOM_REQUESTS = 700;
    localparam int IDLE_PERCENT    = 15;
    // Cycles to let pass once nothing is outstanding.
    localparam int DRAIN_CYCLES    = 20;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_mode;
    logic [30:0] i_seed;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [30:0] o_deviate;

    // Cleared for a long stretch of the random part so that both sides run
    // back to back without idling for a while.
    bit idling_on = 1'b1;

    deviate_scoreboard deviates = new();

    combined_lcg_shuffle_rng dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_mode     (i_mode),
        .i_seed     (i_seed),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_deviate  (o_deviate)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Offers one request and returns at the edge where it is accepted. Valid
    // is left high on return, so that a request that follows at once keeps it
    // high without a second assignment in the same time step; it is lowered
    // only when the sender decides to idle.
    task automatic send_request(input bit mode, input bit [30:0] seed);
        while (idling_on && $urandom_range(99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_seed     <= seed;
        do
            @(posedge i_clk);
        while (!(i_in_valid && o_in_ready));
        deviates.note_request(mode, seed);
    endtask

    // Picks a reseed value: mostly the full 31-bit space, now and then a small
    // value or one close to either modulus.
    function automatic bit [30:0] pick_seed();
        case ($urandom_range(9))
            0:       return 31'($urandom_range(3));
            1:       return SEED_MOD_A - 31'($urandom_range(2)) + 31'd1;
            2:       return SEED_MOD_B - 31'($urandom_range(2)) + 31'd1;
            default: return 31'($urandom);
        endcase
    endfunction

    // Result side: the ready stalls at random, and every deviate accepted at
    // an edge is checked against the oldest expectation. Values are read as
    // they stood just before the edge.
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                deviates.check_deviate(o_deviate);
            i_out_ready <= !(idling_on && $urandom_range(99) < IDLE_PERCENT);
        end
    end

    initial begin
        int k;
        bit mode;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_mode     <= MODE_DRAW;
        i_seed     <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Draws straight out of reset run on the zero table and
        // a zero shuffle output, as any ordinary draw does.
        send_request(MODE_DRAW, '0);
        send_request(MODE_DRAW, SEED_ONES);
        send_request(MODE_DRAW, 31'd12345);
        // A zero seed acts as one, so these two reseeds must give the same deviate.
        send_request(MODE_RESEED, '0);
        send_request(MODE_DRAW, '0);
        send_request(MODE_RESEED, 31'd1);
        send_request(MODE_DRAW, SEED_ONES);
        send_request(MODE_RESEED, SEED_TOP);
        send_request(MODE_DRAW, '0);
        // A seed equal to the first modulus sticks the first generator at zero.
        send_request(MODE_RESEED, SEED_MOD_A);
        send_request(MODE_DRAW, '0);
        send_request(MODE_DRAW, '0);
        // A seed equal to the second modulus sticks the second generator at zero.
        send_request(MODE_RESEED, SEED_MOD_B);
        send_request(MODE_DRAW, '0);
        send_request(MODE_DRAW, SEED_ONES);
        send_request(MODE_RESEED, SEED_ONES);
        send_request(MODE_DRAW, 31'h5555_5555);
        send_request(MODE_DRAW, 31'h2AAA_AAAA);
        // Two reseeds back to back.
        send_request(MODE_RESEED, 31'd2);
        send_request(MODE_RESEED, 31'h2AAA_AAAA);
        send_request(MODE_DRAW, '0);

        // Random part: mostly draws, with reseeds now and then. The seed field
        // carries random data on draws too, where the block must ignore it.
        for (k = 0; k < RANDOM_REQUESTS; k++) begin
            idling_on = !(k >= 250 && k < 400);
            mode = ($urandom_range(99) < 8) ? MODE_RESEED : MODE_DRAW;
            send_request(mode, (mode == MODE_RESEED) ? pick_seed() : 31'($urandom));
        end
        idling_on = 1'b1;
        i_in_valid <= 1'b0;

        while (deviates.expected_deviates.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (deviates.expected_deviates.size() != 0) begin
            $error("%0d deviates never arrived", deviates.expected_deviates.size());
            deviates.n_errors++;
        end
        if (deviates.n_errors == 0) begin
            $display("combined_lcg_shuffle_rng_tb: clean");
        end else begin
            $display("combined_lcg_shuffle_rng_tb: errors");
        end
        $finish;
    end

    // Guard against a hung handshake: far beyond the slowest correct run,
    // every reseed's warm-up included.
    initial begin
        #5ms;
        $display("combined_lcg_shuffle_rng_tb: errors");
        $finish;
    end

endmodule
